[rtl/gcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_pkg
// Shared constants for the gradient color map: default sizes, channel
// widths and command codes.
// ----------------------------------------------------------------------------
package gcm_pkg;

    localparam int MAX_STOPS_DEF     = 8;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CHAN_W   = 8;
    localparam int NUM_CHAN = 3;
    localparam int RGB_W    = CHAN_W * NUM_CHAN;
    localparam int QUOT_W   = CHAN_W;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_LOOKUP = 1'b1
    } cmd_t;

endpackage

[rtl/gcm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module gcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write one word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // register both reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

[rtl/gcm_locate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_locate
// Stop position store and segment search: finds the segment that holds t
// and gives the color addresses, the offset into the segment and its span.
// ----------------------------------------------------------------------------
module gcm_locate
    import gcm_pkg::*;
#(
    parameter int MAX_STOPS     = MAX_STOPS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(MAX_STOPS)-1:0]     wr_idx,
    input  logic [POSITION_BITS-1:0]         wr_pos,
    input  logic [$clog2(MAX_STOPS+1)-1:0]   stop_count,
    input  logic [POSITION_BITS:0]           t,
    output logic [$clog2(MAX_STOPS)-1:0]     addr_lo,
    output logic [$clog2(MAX_STOPS)-1:0]     addr_hi,
    output logic [POSITION_BITS:0]           d,
    output logic [POSITION_BITS:0]           span
);

    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);
    localparam int T_W   = POSITION_BITS + 1;
    localparam logic [T_W-1:0] POS_ONE = T_W'(1) << POSITION_BITS;

    logic [POSITION_BITS-1:0] pos_reg [MAX_STOPS];
    logic [CNT_W-1:0]         n_eff;
    logic [CNT_W-1:0]         n_m1;
    logic [MAX_STOPS-1:0]     lt;
    logic [IDX_W-1:0]         k;
    logic [T_W-1:0]           lower;
    logic [T_W-1:0]           upper;
    logic [T_W-1:0]           span_raw;
    logic [T_W-1:0]           d_raw;

    // store stop positions
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            pos_reg[wr_idx] <= wr_pos;
        end
    end

    // clamp the stop count to its legal range
    always_comb begin
        if (stop_count < CNT_W'(2)) begin
            n_eff = CNT_W'(2);
        end else if (stop_count > CNT_W'(MAX_STOPS)) begin
            n_eff = CNT_W'(MAX_STOPS);
        end else begin
            n_eff = stop_count;
        end
        n_m1 = n_eff - CNT_W'(1);
    end

    // compare t against every inner stop, take the first one not below t
    always_comb begin
        lt    = '0;
        k     = IDX_W'(1);
        lower = '0;
        upper = POS_ONE;
        for (int j = 1; j < MAX_STOPS; j++) begin
            lt[j] = (CNT_W'(j) < n_m1) && ({1'b0, pos_reg[j]} < t);
        end
        for (int j = MAX_STOPS - 1; j >= 1; j--) begin
            if (!lt[j]) begin
                k     = IDX_W'(j);
                upper = (CNT_W'(j) >= n_m1) ? POS_ONE : {1'b0, pos_reg[j]};
                lower = (j == 1) ? '0 : {1'b0, pos_reg[j-1]};
            end
        end
    end

    // offset and span, with the endpoint cases
    always_comb begin
        span_raw = (upper > lower) ? upper - lower : '0;
        d_raw    = (t > lower) ? t - lower : '0;
        if (t == '0) begin
            addr_lo = '0;
            addr_hi = '0;
            d       = '0;
            span    = T_W'(1);
        end else if (t >= POS_ONE) begin
            addr_lo = IDX_W'(n_m1);
            addr_hi = IDX_W'(n_m1);
            d       = '0;
            span    = T_W'(1);
        end else begin
            addr_lo = k - IDX_W'(1);
            addr_hi = k;
            span    = span_raw;
            d       = (d_raw > span_raw) ? span_raw : d_raw;
        end
    end

endmodule

[rtl/gcm_div_stage.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcm_div_stage
// One registered step of a restoring division: decides one quotient bit of
// each color channel.
// ----------------------------------------------------------------------------
module gcm_div_stage
    import gcm_pkg::*;
#(
    parameter int NUM_W = 25,
    parameter int DIV_W = 17,
    parameter int SHIFT = 7
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               valid_in,
    input  logic [NUM_CHAN-1:0][NUM_W-1:0]     rem_in,
    input  logic [DIV_W-1:0]                   div_in,
    input  logic [NUM_CHAN-1:0][QUOT_W-1:0]    quot_in,
    output logic                               valid_out,
    output logic [NUM_CHAN-1:0][NUM_W-1:0]     rem_out,
    output logic [DIV_W-1:0]                   div_out,
    output logic [NUM_CHAN-1:0][QUOT_W-1:0]    quot_out
);

    localparam int CMP_W = NUM_W + 1;

    logic [CMP_W-1:0]                    div_sh;
    logic [NUM_CHAN-1:0][NUM_W-1:0]      rem_next;
    logic [NUM_CHAN-1:0][QUOT_W-1:0]     quot_next;

    // compare and subtract the shifted divisor
    always_comb begin
        div_sh = CMP_W'(div_in) << SHIFT;
        for (int c = 0; c < NUM_CHAN; c++) begin
            quot_next[c] = quot_in[c];
            if (CMP_W'(rem_in[c]) >= div_sh) begin
                rem_next[c]         = rem_in[c] - NUM_W'(div_sh);
                quot_next[c][SHIFT] = 1'b1;
            end else begin
                rem_next[c]         = rem_in[c];
                quot_next[c][SHIFT] = 1'b0;
            end
        end
    end

    // advance valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_out <= 1'b0;
        end else if (en) begin
            valid_out <= valid_in;
        end
    end

    // advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_out  <= rem_next;
            div_out  <= div_in;
            quot_out <= quot_next;
        end
    end

endmodule

[rtl/gradient_color_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_color_map
// Piecewise-linear color gradient lookup over a table of color stops.
// ----------------------------------------------------------------------------
// Takes one transaction per clock. A write transaction (tuser 0) loads one
// stop and gives no result; a lookup (tuser 1) gives one blended RGB result
// at the end of the pipeline. The pipeline is: input register, segment
// search with color read, channel products, then eight restoring division
// steps, one quotient bit per stage. The whole
// pipeline holds while a result waits on m_tready. Stop entries must be
// written before a lookup reads them.
module gradient_color_map
    import gcm_pkg::*;
#(
    parameter int MAX_STOPS     = MAX_STOPS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int IDX_W  = $clog2(MAX_STOPS),
    localparam int CNT_W  = $clog2(MAX_STOPS + 1),
    localparam int T_W    = POSITION_BITS + 1,
    localparam int IN_BITS = IDX_W + RGB_W + POSITION_BITS + T_W,
    localparam int IN_W   = ((IN_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: stop_count
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data,
    // tdata: stop_index, stop_red, stop_green, stop_blue, stop_position,
    //        lookup_position, zero fill
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,
    // tuser: cmd
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata: red, green, blue
    output logic [RGB_W-1:0]  m_tdata
);

    localparam int NUM_W  = CHAN_W + T_W;
    localparam int DIV_N  = QUOT_W;
    localparam int OFS_R  = IDX_W;
    localparam int OFS_G  = OFS_R + CHAN_W;
    localparam int OFS_B  = OFS_G + CHAN_W;
    localparam int OFS_P  = OFS_B + CHAN_W;
    localparam int OFS_T  = OFS_P + POSITION_BITS;

    logic                    en;
    logic [CNT_W-1:0]        stop_count_reg;

    // input register
    logic                    v0_reg;
    cmd_t                    cmd0_reg;
    logic [IDX_W-1:0]        idx0_reg;
    logic [RGB_W-1:0]        color0_reg;
    logic [POSITION_BITS-1:0] pos0_reg;
    logic [T_W-1:0]          t0_reg;

    logic                    wr_en;
    logic [IDX_W-1:0]        addr_lo;
    logic [IDX_W-1:0]        addr_hi;
    logic [T_W-1:0]          d_loc;
    logic [T_W-1:0]          span_loc;

    // search register
    logic                    v1_reg;
    logic [T_W-1:0]          d1_reg;
    logic [T_W-1:0]          span1_reg;
    logic [RGB_W-1:0]        color_lo;
    logic [RGB_W-1:0]        color_hi;

    // product register
    logic                                v2_reg;
    logic [NUM_CHAN-1:0][NUM_W-1:0]      num2_reg;
    logic [NUM_CHAN-1:0][NUM_W-1:0]      num2_next;
    logic [T_W-1:0]                      div2_reg;
    logic [T_W-1:0]                      div2_next;

    // division chain
    logic [DIV_N:0]                              dv;
    logic [DIV_N:0][NUM_CHAN-1:0][NUM_W-1:0]     drem;
    logic [DIV_N:0][T_W-1:0]                     ddiv;
    logic [DIV_N:0][NUM_CHAN-1:0][QUOT_W-1:0]    dquot;

    // stall the whole pipeline while a result waits
    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    // hold the stop count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_count_reg <= CNT_W'(2);
        end else if (cfg_valid && cfg_ready) begin
            stop_count_reg <= cfg_data;
        end
    end

    // capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd0_reg   <= cmd_t'(s_tuser[0]);
            idx0_reg   <= s_tdata[IDX_W-1:0];
            color0_reg <= {s_tdata[OFS_B +: CHAN_W], s_tdata[OFS_G +: CHAN_W],
                           s_tdata[OFS_R +: CHAN_W]};
            pos0_reg   <= s_tdata[OFS_P +: POSITION_BITS];
            t0_reg     <= s_tdata[OFS_T +: T_W];
        end
    end

    // commit a stop write in order with the lookups
    assign wr_en = en && v0_reg && (cmd0_reg == CMD_WRITE) &&
                   ({1'b0, idx0_reg} < (IDX_W + 1)'(MAX_STOPS));

    gcm_locate #(
        .MAX_STOPS     (MAX_STOPS),
        .POSITION_BITS (POSITION_BITS)
    ) u_locate (
        .aclk       (aclk),
        .wr_en      (wr_en),
        .wr_idx     (idx0_reg),
        .wr_pos     (pos0_reg),
        .stop_count (stop_count_reg),
        .t          (t0_reg),
        .addr_lo    (addr_lo),
        .addr_hi    (addr_hi),
        .d          (d_loc),
        .span       (span_loc)
    );

    gcm_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_STOPS)
    ) u_color_ram (
        .aclk    (aclk),
        .we      (wr_en),
        .waddr   (idx0_reg),
        .wdata   (color0_reg),
        .re      (en),
        .raddr_a (addr_lo),
        .raddr_b (addr_hi),
        .rdata_a (color_lo),
        .rdata_b (color_hi)
    );

    // register the segment offset and span
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg && (cmd0_reg == CMD_LOOKUP);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_reg    <= d_loc;
            span1_reg <= span_loc;
        end
    end

    // form the blend numerators; a zero span passes the upper color
    always_comb begin
        div2_next = (span1_reg == '0) ? T_W'(1) : span1_reg;
        for (int c = 0; c < NUM_CHAN; c++) begin
            if (span1_reg == '0) begin
                num2_next[c] = NUM_W'(color_hi[c*CHAN_W +: CHAN_W]);
            end else begin
                num2_next[c] = NUM_W'(color_lo[c*CHAN_W +: CHAN_W]) *
                               NUM_W'(span1_reg - d1_reg) +
                               NUM_W'(color_hi[c*CHAN_W +: CHAN_W]) * NUM_W'(d1_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num2_reg <= num2_next;
            div2_reg <= div2_next;
        end
    end

    // divide, most significant quotient bit first
    assign dv[0]    = v2_reg;
    assign drem[0]  = num2_reg;
    assign ddiv[0]  = div2_reg;
    assign dquot[0] = '0;

    for (genvar i = 0; i < DIV_N; i++) begin : g_div
        gcm_div_stage #(
            .NUM_W (NUM_W),
            .DIV_W (T_W),
            .SHIFT (DIV_N - 1 - i)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (dv[i]),
            .rem_in    (drem[i]),
            .div_in    (ddiv[i]),
            .quot_in   (dquot[i]),
            .valid_out (dv[i+1]),
            .rem_out   (drem[i+1]),
            .div_out   (ddiv[i+1]),
            .quot_out  (dquot[i+1])
        );
    end

    // present the result
    assign m_tvalid = dv[DIV_N];
    assign m_tdata  = dquot[DIV_N];

endmodule
